FILE: design/tpsr_pkg.sv
package tpsr_pkg;

   // fixed field widths
   localparam int unsigned LENGTH_WIDTH = 4;
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned COORD_WIDTH  = 16;
   localparam int unsigned FLAGS_WIDTH  = 6;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // packet and report constants
   localparam logic [LENGTH_WIDTH-1:0] MIN_PACKET_LENGTH = 4'd6;
   localparam logic [FLAGS_WIDTH-1:0]  FLAGS_BASE        = 6'h20;
   localparam int unsigned FLAG_PROX   = 0;
   localparam int unsigned FLAG_TIP    = 1;
   localparam int unsigned FLAG_SIDE   = 2;
   localparam int unsigned FLAG_ERASER = 3;

   // reset values
   localparam logic [COORD_WIDTH-1:0] MAX_Y_RESET          = 16'd10239;
   localparam logic [BYTE_WIDTH-1:0]  PRESSURE_FLOOR_RESET = 8'h80;
   localparam logic [BYTE_WIDTH-1:0]  HELD_PRESSURE_RESET  = 8'h80;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_Y          = 1'b0,
      CSR_PRESSURE_FLOOR = 1'b1
   } csr_index_type;

   // packet kind in byte4 bits 7..6
   typedef enum logic [1:0] {
      KIND_TILT     = 2'd0,
      KIND_HEIGHT   = 2'd1,
      KIND_PRESSURE = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [LENGTH_WIDTH-1:0] packet_length;
      logic [BYTE_WIDTH-1:0]   byte0;
      logic [BYTE_WIDTH-1:0]   byte1;
      logic [BYTE_WIDTH-1:0]   byte2;
      logic [BYTE_WIDTH-1:0]   byte3;
      logic [BYTE_WIDTH-1:0]   byte4;
      logic [BYTE_WIDTH-1:0]   byte5;
   } packet_type;

   typedef struct packed {
      logic                   packet_error;
      logic [COORD_WIDTH-1:0] pos_x;
      logic [COORD_WIDTH-1:0] pos_y;
      logic [BYTE_WIDTH-1:0]  pen_pressure;
      logic [BYTE_WIDTH-1:0]  tilt_x;
      logic [BYTE_WIDTH-1:0]  tilt_y;
      logic [FLAGS_WIDTH-1:0] report_flags;
   } report_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] max_y;
      logic [BYTE_WIDTH-1:0]  pressure_floor;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] tilt_x;
      logic [BYTE_WIDTH-1:0] tilt_y;
      logic [BYTE_WIDTH-1:0] pressure;
      logic                  pressure_enabled;
   } held_type;

endpackage

FILE: design/tpsr_req_if.sv
interface tpsr_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] packet_length;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] byte3;
   logic [7:0] byte4;
   logic [7:0] byte5;

   modport source (output valid, packet_length, byte0, byte1, byte2, byte3, byte4, byte5,
                   input ready);
   modport sink   (input valid, packet_length, byte0, byte1, byte2, byte3, byte4, byte5,
                   output ready);
endinterface

FILE: design/tpsr_rsp_if.sv
interface tpsr_rsp_if;
   logic              valid;
   logic              ready;
   logic              packet_error;
   logic [15:0]       pos_x;
   logic [15:0]       pos_y;
   logic signed [7:0] pen_pressure;
   logic signed [7:0] tilt_x;
   logic signed [7:0] tilt_y;
   logic [5:0]        report_flags;

   modport source (output valid, packet_error, pos_x, pos_y, pen_pressure, tilt_x, tilt_y,
                   report_flags, input ready);
   modport sink   (input valid, packet_error, pos_x, pos_y, pen_pressure, tilt_x, tilt_y,
                   report_flags, output ready);
endinterface

FILE: design/tpsr_csr_if.sv
interface tpsr_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tpsr_csr_regs.sv
module tpsr_csr_regs (
   input  logic               clock,
   input  logic               reset,
   tpsr_csr_if.sink           csr_chan,
   output tpsr_pkg::cfg_type  cfg
);

   tpsr_pkg::cfg_type cfg_ff;

   // writes are always taken
   assign csr_chan.ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_y          <= tpsr_pkg::MAX_Y_RESET;
         cfg_ff.pressure_floor <= tpsr_pkg::PRESSURE_FLOOR_RESET;
      end else if (csr_chan.valid) begin
         case (tpsr_pkg::csr_index_type'(csr_chan.index))
            tpsr_pkg::CSR_MAX_Y: begin
               cfg_ff.max_y <= csr_chan.data;
            end
            tpsr_pkg::CSR_PRESSURE_FLOOR: begin
               cfg_ff.pressure_floor <= csr_chan.data[tpsr_pkg::BYTE_WIDTH-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/tpsr_decode.sv
module tpsr_decode (
   input  tpsr_pkg::packet_type packet,
   input  tpsr_pkg::cfg_type    cfg,
   input  tpsr_pkg::held_type   held,
   output tpsr_pkg::report_type report,
   output tpsr_pkg::held_type   held_next
);

   logic                              prox;
   logic                              tip_sw;
   logic                              side_sw;
   logic                              eraser_sw;
   tpsr_pkg::kind_type                kind;
   logic [tpsr_pkg::BYTE_WIDTH-1:0]   pres;
   logic [tpsr_pkg::BYTE_WIDTH-1:0]   tx;
   logic [tpsr_pkg::BYTE_WIDTH-1:0]   ty;
   logic [tpsr_pkg::BYTE_WIDTH-1:0]   tilt2;
   logic [tpsr_pkg::FLAGS_WIDTH-1:0]  flags;
   logic [tpsr_pkg::COORD_WIDTH-1:0]  raw_y;

   assign prox      = packet.byte0[7];
   assign tip_sw    = packet.byte4[1];
   assign side_sw   = packet.byte4[2];
   assign eraser_sw = packet.byte4[3];
   assign kind      = tpsr_pkg::kind_type'(packet.byte4[7:6]);
   assign raw_y     = {1'b0, packet.byte0[6:0], packet.byte1};
   // 7-bit signed tilt doubled: low seven bits shifted up, bit 6 lands in the sign
   assign tilt2     = {packet.byte5[6:0], 1'b0};

   // pressure and tilt selection by packet kind
   always_comb begin
      tx        = held.tilt_x;
      ty        = held.tilt_y;
      pres      = held.pressure_enabled ? held.pressure : cfg.pressure_floor;
      held_next = held;
      case (kind)
         tpsr_pkg::KIND_PRESSURE: begin
            if (held.pressure_enabled) begin
               pres               = cfg.pressure_floor + {packet.byte4[0], packet.byte5[7:1]};
               held_next.pressure = pres;
            end
         end
         tpsr_pkg::KIND_HEIGHT: begin
            if (held.pressure_enabled && (packet.byte5 != '0)) begin
               pres               = cfg.pressure_floor;
               held_next.pressure = pres;
            end
         end
         tpsr_pkg::KIND_TILT: begin
            if (!packet.byte5[7]) begin
               tx               = tilt2;
               held_next.tilt_x = tx;
            end else begin
               ty               = -tilt2;
               held_next.tilt_y = ty;
            end
         end
         default: begin
            held_next = held;
         end
      endcase

      // out of proximity, side switch 1 toggles pressure reporting
      if (!prox && side_sw) begin
         held_next.pressure_enabled = !held.pressure_enabled;
      end

      // short packet leaves state alone
      if (packet.packet_length < tpsr_pkg::MIN_PACKET_LENGTH) begin
         held_next = held;
      end
   end

   // status flags
   always_comb begin
      flags = tpsr_pkg::FLAGS_BASE;
      if (prox) begin
         flags[tpsr_pkg::FLAG_PROX]   = 1'b1;
         flags[tpsr_pkg::FLAG_TIP]    = tip_sw && !held.pressure_enabled;
         flags[tpsr_pkg::FLAG_SIDE]   = side_sw;
         flags[tpsr_pkg::FLAG_ERASER] = eraser_sw;
      end
   end

   // report word
   always_comb begin
      if (packet.packet_length < tpsr_pkg::MIN_PACKET_LENGTH) begin
         report              = '0;
         report.packet_error = 1'b1;
      end else begin
         report.packet_error = 1'b0;
         report.pos_x        = {packet.byte2, packet.byte3};
         report.pos_y        = cfg.max_y - raw_y;
         report.pen_pressure = pres;
         report.tilt_x       = tx;
         report.tilt_y       = ty;
         report.report_flags = flags;
      end
   end

endmodule

FILE: design/tablet_packet_to_stylus_report_core.sv
// Path: a word accepted on req_chan is registered in the input stage, goes through
//    one pass of decode logic, and is registered in the result stage for rsp_chan.
// Throughput: one word per cycle unless rsp_chan stalls; both register stages
//    advance together; an empty input stage still fills while a report waits.
// Reset (synchronous, active high): clears both stage valids, loads max_y and
//    pressure_floor reset values, zeroes held tilts, held pressure to -128.
module tablet_packet_to_stylus_report_core (
   input  logic        clock,
   input  logic        reset,
   tpsr_req_if.sink    req_chan,
   tpsr_rsp_if.source  rsp_chan,
   tpsr_csr_if.sink    csr_chan
);

   tpsr_pkg::cfg_type    cfg;
   tpsr_pkg::packet_type packet_in;
   tpsr_pkg::packet_type packet_ff;
   logic                 stage_valid_ff;
   tpsr_pkg::report_type report_in;
   tpsr_pkg::report_type report_ff;
   logic                 rsp_valid_ff;
   tpsr_pkg::held_type   held_ff;
   tpsr_pkg::held_type   held_in;
   logic                 advance;
   logic                 req_ready;

   // configuration registers
   tpsr_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // handshake control
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_chan.ready = req_ready;

   assign packet_in.packet_length = req_chan.packet_length;
   assign packet_in.byte0         = req_chan.byte0;
   assign packet_in.byte1         = req_chan.byte1;
   assign packet_in.byte2         = req_chan.byte2;
   assign packet_in.byte3         = req_chan.byte3;
   assign packet_in.byte4         = req_chan.byte4;
   assign packet_in.byte5         = req_chan.byte5;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         packet_ff <= packet_in;
      end
   end

   // decode pass
   tpsr_decode u_decode (
      .packet    (packet_ff),
      .cfg       (cfg),
      .held      (held_ff),
      .report    (report_in),
      .held_next (held_in)
   );

   // held tilts, pressure and enable
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.tilt_x           <= '0;
         held_ff.tilt_y           <= '0;
         held_ff.pressure         <= tpsr_pkg::HELD_PRESSURE_RESET;
         held_ff.pressure_enabled <= 1'b1;
      end else if (advance) begin
         held_ff <= held_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         report_ff <= report_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.packet_error = report_ff.packet_error;
   assign rsp_chan.pos_x        = report_ff.pos_x;
   assign rsp_chan.pos_y        = report_ff.pos_y;
   assign rsp_chan.pen_pressure = report_ff.pen_pressure;
   assign rsp_chan.tilt_x       = report_ff.tilt_x;
   assign rsp_chan.tilt_y       = report_ff.tilt_y;
   assign rsp_chan.report_flags = report_ff.report_flags;

   // both stages full and output stalled: no new word may enter
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_ready)
      else $error("input accepted while pipeline is blocked");

   // an error report carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && report_ff.packet_error) |->
         (report_ff.pos_x == '0 && report_ff.pos_y == '0 && report_ff.pen_pressure == '0 &&
          report_ff.tilt_x == '0 && report_ff.tilt_y == '0 && report_ff.report_flags == '0))
      else $error("error report has nonzero fields");

   // a good report always has the base flag set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !report_ff.packet_error) |-> report_ff.report_flags[5])
      else $error("report missing base flag");

   // held state changes only when a word passes through decode
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(held_ff))
      else $error("held state changed without a word");

endmodule
